// ===== rtl/core/cobs_frame_receiver_top_defines.svh =====
// Assertion macros shared by the COBS frame receiver RTL.
`ifndef COBS_FRAME_RECEIVER_TOP_DEFINES_SVH
`define COBS_FRAME_RECEIVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Invariant checked on every rising clock edge outside reset.
`define CFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define CFR_ASSERT(lbl, prop, msg)
`define CFR_ASSERT_IMPL(lbl, ante, cons, msg)
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/cfr_pkg.sv =====
// Shared types and constants of the COBS frame receiver.
`default_nettype none

package cfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int INDEX_W     = 6;
  localparam int LENGTH_W    = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 24;

  // Frame delimiter and the code that carries no implied zero.
  localparam logic [BYTE_W-1:0] DELIM_BYTE    = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_FULL_RUN = 8'hFF;

  // Result word, first field in the highest bits.
  typedef struct packed {
    logic [LENGTH_W-1:0] packet_length;
    logic [INDEX_W-1:0]  byte_index;
    logic [BYTE_W-1:0]   data_byte;
  } cfr_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/cobs_frame_receiver_top.sv =====
// COBS frame receiver: sync, frame buffering, validation and decoded byte delivery.
`default_nettype none
`include "cobs_frame_receiver_top_defines.svh"

// Receives serial bytes on the in_ stream (in_tuser flags a line error, which drops sync
// and the buffered frame). Bytes are ignored until a zero delimiter syncs the receiver;
// then non-zero bytes are buffered in a RAM of MAX_PACKET+1 entries, one byte per cycle,
// and a zero byte ends the frame. On a delimiter the block stops taking words and a
// sequencer walks the buffer through the single RAM read port twice: a scan pass that
// checks the frame and sizes the packet, one code byte at a time, then a delivery pass
// that emits one word per decoded byte and holds each word until out_tready accepts it.
// Invalid, truncated or oversized frames produce nothing; a frame that decodes to no
// bytes yields a single word with packet_length 0.
module cobs_frame_receiver_top #(
  parameter int MAX_PACKET = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [cfr_pkg::IN_TDATA_W-1:0] in_tdata,   // [7:0] rx_byte
  input  wire logic [cfr_pkg::IN_TUSER_W-1:0] in_tuser,   // [0] line_error
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [cfr_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [7:0] data_byte,
                                                          // [13:8] byte_index,
                                                          // [20:14] packet_length
  output logic                                out_tlast   // last
);

  import cfr_pkg::*;

  localparam int STORE_DEPTH = MAX_PACKET + 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SUM_W       = ((CNT_W > BYTE_W) ? CNT_W : BYTE_W) + 1;

  localparam logic [CNT_W-1:0] STORE_DEPTH_C = CNT_W'(STORE_DEPTH);
  localparam logic [SUM_W-1:0] MAX_SUM_C     = SUM_W'(MAX_PACKET);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EVAL,
    S_CODE_RD,
    S_CODE_EVAL,
    S_DATA_RD,
    S_DATA_EVAL,
    S_STEP,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic                synced_r, synced_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    ptr_r, ptr_nxt;
  logic [CNT_W-1:0]    wr_r, wr_nxt;
  logic [CNT_W-1:0]    len_r, len_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [BYTE_W-1:0]   run_r, run_nxt;
  logic                zero_due_r, zero_due_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_last_r, out_last_nxt;
  cfr_out_t            out_word_r, out_word_nxt;

  logic                accept;
  logic [BYTE_W-1:0]   in_byte;
  logic                in_err;
  logic                ram_we;
  logic [BYTE_W-1:0]   ram_rdata;
  logic [BYTE_W-1:0]   code_run;
  logic [CNT_W-1:0]    rd_next;
  logic [SUM_W-1:0]    sum_rd;
  logic [SUM_W-1:0]    sum_wr;
  logic                idx_is_last;

  assign in_byte = in_tdata[BYTE_W-1:0];
  assign in_err  = in_tuser[0];
  assign accept  = in_tvalid && in_tready;

  // Frame buffer.
  cfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_byte),
    .raddr (ptr_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Pointer and length arithmetic for the scan and delivery passes.
  assign code_run    = ram_rdata - 8'd1;
  assign rd_next     = ptr_r + CNT_W'(1);
  assign sum_rd      = SUM_W'(rd_next) + SUM_W'(code_run);
  assign sum_wr      = SUM_W'(wr_r) + SUM_W'(code_run);
  assign idx_is_last = (idx_r + CNT_W'(1)) == len_r;

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    synced_nxt    = synced_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    wr_nxt        = wr_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    run_nxt       = run_r;
    zero_due_nxt  = zero_due_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_err) begin
            synced_nxt = 1'b0;
            count_nxt  = '0;
          end else if (!synced_r) begin
            synced_nxt = (in_byte == DELIM_BYTE);
          end else if (in_byte == DELIM_BYTE) begin
            if (count_r != '0) begin
              ptr_nxt   = '0;
              wr_nxt    = '0;
              state_nxt = S_SCAN_RD;
            end
          end else if (count_r >= STORE_DEPTH_C) begin
            // Overflow: drop the frame and resync.
            count_nxt  = '0;
            synced_nxt = 1'b0;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_EVAL;
      end

      // Check one code byte and advance the decoded length.
      S_SCAN_EVAL: begin
        if (ram_rdata == DELIM_BYTE || sum_rd > SUM_W'(count_r) || sum_wr > MAX_SUM_C) begin
          count_nxt = '0;
          state_nxt = S_IDLE;
        end else if (sum_rd == SUM_W'(count_r)) begin
          len_nxt = CNT_W'(sum_wr);
          ptr_nxt = '0;
          idx_nxt = '0;
          if (sum_wr == '0) begin
            // Empty packet marker.
            out_word_nxt  = '0;
            out_last_nxt  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            state_nxt = S_CODE_RD;
          end
        end else if (ram_rdata != CODE_FULL_RUN) begin
          if (sum_wr >= MAX_SUM_C) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            wr_nxt    = CNT_W'(sum_wr) + CNT_W'(1);
            ptr_nxt   = CNT_W'(sum_rd);
            state_nxt = S_SCAN_RD;
          end
        end else begin
          wr_nxt    = CNT_W'(sum_wr);
          ptr_nxt   = CNT_W'(sum_rd);
          state_nxt = S_SCAN_RD;
        end
      end

      S_CODE_RD: begin
        state_nxt = S_CODE_EVAL;
      end

      // Latch the run length of the next block.
      S_CODE_EVAL: begin
        run_nxt      = code_run;
        zero_due_nxt = (ram_rdata != CODE_FULL_RUN);
        ptr_nxt      = rd_next;
        state_nxt    = (code_run == '0) ? S_STEP : S_DATA_RD;
      end

      S_DATA_RD: begin
        state_nxt = S_DATA_EVAL;
      end

      // Present one copied byte.
      S_DATA_EVAL: begin
        out_word_nxt.data_byte     = ram_rdata;
        out_word_nxt.byte_index    = INDEX_W'(idx_r);
        out_word_nxt.packet_length = LENGTH_W'(len_r);
        out_last_nxt               = idx_is_last;
        out_valid_nxt              = 1'b1;
        ptr_nxt                    = rd_next;
        run_nxt                    = run_r - 8'd1;
        idx_nxt                    = idx_r + CNT_W'(1);
        state_nxt                  = S_OUT;
      end

      // After a run: emit the implied zero or fetch the next code.
      S_STEP: begin
        if (zero_due_r && ptr_r < count_r) begin
          out_word_nxt.data_byte     = DELIM_BYTE;
          out_word_nxt.byte_index    = INDEX_W'(idx_r);
          out_word_nxt.packet_length = LENGTH_W'(len_r);
          out_last_nxt               = idx_is_last;
          out_valid_nxt              = 1'b1;
          zero_due_nxt               = 1'b0;
          idx_nxt                    = idx_r + CNT_W'(1);
          state_nxt                  = S_OUT;
        end else begin
          state_nxt = S_CODE_RD;
        end
      end

      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else if (run_r != '0) begin
            state_nxt = S_DATA_RD;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      synced_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      synced_r    <= synced_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r      <= ptr_nxt;
    wr_r       <= wr_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    run_r      <= run_nxt;
    zero_due_r <= zero_due_nxt;
    out_last_r <= out_last_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'(out_word_r);

  // Checks on the sequencer.
  `CFR_ASSERT_IMPL(a_no_input_while_out, out_tvalid, !in_tready, "input taken while a word is pending")
  `CFR_ASSERT(a_count_bound, count_r <= STORE_DEPTH_C, "frame byte count beyond buffer depth")
  `CFR_ASSERT_IMPL(a_last_index, out_tvalid && out_tlast && len_r != '0, idx_r == len_r, "last word not at packet end")
  `CFR_ASSERT_IMPL(a_index_bound, out_tvalid, idx_r <= len_r, "byte index beyond packet length")
  `CFR_ASSERT_NEXT(a_busy_mid_packet, out_tvalid && out_tready && !out_tlast, !in_tready, "receiver idle in mid packet")

endmodule

`default_nettype wire

// ===== rtl/core/cfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== tb/cfr_checker.sv =====
// Scoreboard for the COBS frame receiver: predicts decoded packets from input words and checks output words.
module cfr_checker #(
  parameter int MAX_PACKET = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [cfr_pkg::IN_TDATA_W-1:0] in_tdata,   // [7:0] rx_byte
  input  logic [cfr_pkg::IN_TUSER_W-1:0] in_tuser,   // [0] line_error
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [cfr_pkg::OUT_TDATA_W-1:0] out_tdata, // [7:0] data_byte, [13:8] byte_index,
                                                     // [20:14] packet_length
  input  logic                           out_tlast,
  output int                             error_count,
  output int                             pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfr_pkg::*;

  localparam int STORE_DEPTH = MAX_PACKET + 1;

  typedef struct packed {
    logic     last;
    cfr_out_t fields;
  } decoded_word_t;

  // Shadow copy of the receiver state.
  logic                synced;
  int                  frame_len;
  logic [BYTE_W-1:0]   frame_buf [STORE_DEPTH];
  decoded_word_t       decoded_q [$];

  decoded_word_t       want;
  cfr_out_t            got;
  int                  mismatches = 0;

  assign error_count = mismatches;

  task automatic report_mismatch(input string what, input int got_val, input int want_val);
    mismatches++;
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got_val, want_val);
  endtask

  // Undo the byte stuffing of the buffered frame and queue the packet it carries.
  // An invalid frame queues nothing.
  function automatic void unstuff_frame();
    logic [BYTE_W-1:0] pkt [MAX_PACKET];
    decoded_word_t     w;
    int                rd;
    int                wr;
    int                code;
    int                run;
    logic              ok;

    ok = 1'b1;
    rd = 0;
    wr = 0;
    while (ok && rd < frame_len) begin
      code = frame_buf[rd];
      rd++;
      if (code == DELIM_BYTE) begin
        ok = 1'b0;
      end else begin
        run = code - 1;
        if (rd + run > frame_len || wr + run > MAX_PACKET) begin
          ok = 1'b0;
        end else begin
          for (int k = 0; k < run; k++) begin
            pkt[wr + k] = frame_buf[rd + k];
          end
          rd += run;
          wr += run;
          // Every block but a full run and the final one ends in an implied zero.
          if (code != CODE_FULL_RUN && rd < frame_len) begin
            if (wr >= MAX_PACKET) begin
              ok = 1'b0;
            end else begin
              pkt[wr] = DELIM_BYTE;
              wr++;
            end
          end
        end
      end
    end
    if (!ok) return;

    if (wr == 0) begin
      // An empty packet still gets one marker word.
      w = '0;
      w.last = 1'b1;
      decoded_q.push_back(w);
    end else begin
      for (int i = 0; i < wr; i++) begin
        w.fields.data_byte     = pkt[i];
        w.fields.byte_index    = i[INDEX_W-1:0];
        w.fields.packet_length = wr[LENGTH_W-1:0];
        w.last                 = (i + 1 == wr);
        decoded_q.push_back(w);
      end
    end
  endfunction

  // Advance the shadow state by one received byte.
  function automatic void take_rx_byte(input logic [BYTE_W-1:0] b, input logic line_err);
    if (line_err) begin
      synced    = 1'b0;
      frame_len = 0;
    end else if (!synced) begin
      synced = (b == DELIM_BYTE);
    end else if (b == DELIM_BYTE) begin
      if (frame_len > 0) unstuff_frame();
      frame_len = 0;
    end else if (frame_len >= STORE_DEPTH) begin
      // Overflow drops the frame and sync.
      frame_len = 0;
      synced    = 1'b0;
    end else begin
      frame_buf[frame_len] = b;
      frame_len++;
    end
  endfunction

  // Watch both channels; an accepted input word is predicted before any output word is checked.
  always @(posedge clk) begin
    if (!rst_n) begin
      synced    = 1'b0;
      frame_len = 0;
      decoded_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        take_rx_byte(in_tdata[BYTE_W-1:0], in_tuser[0]);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(cfr_out_t)-1:0];
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, 0);
        end else begin
          want = decoded_q.pop_front();
          // The data byte carries no meaning in the empty-packet marker.
          if (want.fields.packet_length != 0 && got.data_byte !== want.fields.data_byte) begin
            report_mismatch("data_byte", got.data_byte, want.fields.data_byte);
          end
          if (got.byte_index !== want.fields.byte_index) begin
            report_mismatch("byte_index", got.byte_index, want.fields.byte_index);
          end
          if (got.packet_length !== want.fields.packet_length) begin
            report_mismatch("packet_length", got.packet_length, want.fields.packet_length);
          end
          if (out_tlast !== want.last) begin
            report_mismatch("last", out_tlast, want.last);
          end
          if (out_tdata[OUT_TDATA_W-1:$bits(cfr_out_t)] !== '0) begin
            report_mismatch("tdata padding", out_tdata[OUT_TDATA_W-1:$bits(cfr_out_t)], 0);
          end
        end
      end
    end
    pending_count <= decoded_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top-level testbench of the COBS frame receiver: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfr_pkg::*;

  localparam int MAX_PACKET = 64;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;   // [7:0] rx_byte
  logic [IN_TUSER_W-1:0]   in_tuser   = '0;   // [0] line_error
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;         // [7:0] data_byte, [13:8] byte_index,
                                              // [20:14] packet_length
  logic                    out_tlast;
  int                      error_count;
  int                      pending_count;

  int                      send_idle_pct = 0;
  int                      recv_idle_pct = 0;
  int                      words_sent    = 0;

  cobs_frame_receiver_top #(
    .MAX_PACKET(MAX_PACKET)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  cfr_checker #(
    .MAX_PACKET(MAX_PACKET)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output backpressure at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one word and return at the edge that accepts it.
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic line_err);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tuser[0] <= line_err;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Byte-stuff a packet, send it and close it with a delimiter.
  task automatic send_packet(input logic [BYTE_W-1:0] pkt [$]);
    logic [BYTE_W-1:0] frame [$];
    int                code_pos;
    int                code;

    frame    = {8'h01};
    code_pos = 0;
    code     = 1;
    foreach (pkt[i]) begin
      if (pkt[i] == DELIM_BYTE) begin
        frame[code_pos] = BYTE_W'(code);
        code_pos        = frame.size();
        frame.push_back(8'h01);
        code            = 1;
      end else begin
        frame.push_back(pkt[i]);
        code++;
      end
    end
    frame[code_pos] = BYTE_W'(code);
    foreach (frame[i]) send_word(frame[i], 1'b0);
    send_word(DELIM_BYTE, 1'b0);
    words_sent += frame.size() + 1;
  endtask

  // Send n random non-zero bytes and a delimiter, a frame with arbitrary codes.
  task automatic send_raw_frame(input int n);
    for (int i = 0; i < n; i++) send_word(BYTE_W'($urandom_range(255, 1)), 1'b0);
    send_word(DELIM_BYTE, 1'b0);
    words_sent += n + 1;
  endtask

  // Random traffic, mostly well-formed frames, at one pair of idle rates.
  task automatic run_phase(input int s_pct, input int r_pct, input int budget);
    logic [BYTE_W-1:0] pkt [$];
    int                start;
    int                pick;
    int                len;
    int                size_pick;

    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start         = words_sent;
    while (words_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // Mostly short packets, a few near or past the size limit.
        size_pick = $urandom_range(99);
        if (size_pick < 85) len = $urandom_range(12, 0);
        else if (size_pick < 95) len = $urandom_range(59, 13);
        else len = $urandom_range(MAX_PACKET + 1, 60);
        pkt.delete();
        for (int i = 0; i < len; i++) begin
          pkt.push_back(($urandom_range(3) == 0) ? DELIM_BYTE : BYTE_W'($urandom_range(255, 1)));
        end
        send_packet(pkt);
      end else if (pick < 82) begin
        send_raw_frame($urandom_range(8, 1));
      end else if (pick < 87) begin
        // Longer than the frame buffer.
        send_raw_frame($urandom_range(MAX_PACKET + 6, MAX_PACKET + 2));
      end else if (pick < 93) begin
        send_word(BYTE_W'($urandom_range(255)), 1'b1);
        words_sent++;
      end else begin
        send_word(BYTE_W'($urandom_range(255)), 1'b0);
        words_sent++;
      end
    end
  endtask

  // Stimulus.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 59;

    // Bytes before sync are dropped; a line error on a zero byte does not sync.
    send_word(8'h5A, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(DELIM_BYTE, 1'b1);
    send_word(DELIM_BYTE, 1'b0);
    // Delimiter on an empty buffer.
    send_word(DELIM_BYTE, 1'b0);
    // Frame decoding to an empty packet.
    send_word(8'h01, 1'b0);
    send_word(DELIM_BYTE, 1'b0);
    // Single byte of all ones.
    send_word(8'h02, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(DELIM_BYTE, 1'b0);
    // Truncated frame.
    send_word(8'h03, 1'b0);
    send_word(8'h11, 1'b0);
    send_word(DELIM_BYTE, 1'b0);
    // Packet holding one zero byte.
    send_word(8'h01, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(DELIM_BYTE, 1'b0);
    // Line error in mid-frame, then resync.
    send_word(8'h02, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hAA, 1'b1);
    send_word(DELIM_BYTE, 1'b0);
    // Two-byte packet.
    send_word(8'h03, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(DELIM_BYTE, 1'b0);

    run_phase(36, 59, 100);
    run_phase(59, 36, 100);
    run_phase(0, 0, 100);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // Room for a late decode of the last frame to show up.
    repeat (500) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== cobs_frame_receiver_top.f =====
+incdir+rtl/core
rtl/core/cfr_pkg.sv
rtl/core/cfr_ram.sv
rtl/core/cobs_frame_receiver_top.sv
tb/cfr_checker.sv
tb/tb.sv
